// ----- hdl/u8cp_pkg.sv -----
package u8cp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned CNT_W  = 2;
    localparam int unsigned TDATA_OUT_W = 24;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    typedef enum logic [2:0] {
        LEAD_ASCII   = 3'd0,
        LEAD_TWO     = 3'd1,
        LEAD_THREE   = 3'd2,
        LEAD_FOUR    = 3'd3,
        LEAD_INVALID = 3'd4
    } t_lead_kind;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } t_in_word;

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] code_point;
        logic            final_code_point;
    } t_result;

    function automatic t_lead_kind lead_kind(input logic [BYTE_W-1:0] b);
        t_lead_kind k;
        case (b[7:3]) inside
            5'b0????: k = LEAD_ASCII;
            5'b110??: k = LEAD_TWO;
            5'b1110?: k = LEAD_THREE;
            5'b11110: k = LEAD_FOUR;
            default:  k = LEAD_INVALID;
        endcase
        return k;
    endfunction

endpackage

// ----- hdl/u8cp_in_reg.sv -----
module u8cp_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    input  logic               i_advance,
    output u8cp_pkg::t_in_word o_word
);
    import u8cp_pkg::*;

    t_in_word r_word;
    t_in_word n_word;

    assign o_ready = !r_word.valid || i_advance;
    assign o_word  = r_word;

    always_comb begin
        n_word = r_word;
        if (o_ready) begin
            n_word.valid       = i_valid;
            n_word.text_byte   = i_byte;
            n_word.end_of_text = i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else begin
            r_word.valid <= n_word.valid;
        end
        r_word.text_byte   <= n_word.text_byte;
        r_word.end_of_text <= n_word.end_of_text;
    end

endmodule

// ----- hdl/u8cp_decode.sv -----
module u8cp_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  u8cp_pkg::t_in_word i_word,
    input  logic               i_advance,
    output u8cp_pkg::t_result  o_result
);
    import u8cp_pkg::*;

    logic [CNT_W-1:0] r_expected;
    logic [CNT_W-1:0] n_expected;
    logic [CP_W-1:0]  r_partial;
    logic [CP_W-1:0]  n_partial;
    logic             r_discard;
    logic             n_discard;
    logic [CNT_W-1:0] cnt_dec;
    logic [CP_W-1:0]  shifted;
    logic             eot;
    logic [7:0]       b;

    assign b       = i_word.text_byte;
    assign eot     = i_word.end_of_text;
    assign cnt_dec = r_expected - CNT_W'(1);
    assign shifted = {r_partial[CP_W-7:0], b[5:0]};

    always_comb begin
        n_expected = r_expected;
        n_partial  = r_partial;
        n_discard  = r_discard;
        o_result.valid            = 1'b0;
        o_result.code_point       = REPLACEMENT_CP;
        o_result.final_code_point = 1'b1;
        if (r_discard) begin
            n_discard = !eot;
        end else if (r_expected != '0) begin
            // continuation word
            n_expected = cnt_dec;
            n_partial  = shifted;
            if (cnt_dec == '0) begin
                o_result.valid            = 1'b1;
                o_result.code_point       = shifted;
                o_result.final_code_point = eot;
                n_partial                 = '0;
            end else if (eot) begin
                o_result.valid = 1'b1;
                n_expected     = '0;
                n_partial      = '0;
            end
        end else begin
            unique case (lead_kind(b))
                LEAD_ASCII: begin
                    o_result.valid            = 1'b1;
                    o_result.code_point       = CP_W'(b);
                    o_result.final_code_point = eot;
                end
                LEAD_TWO: begin
                    n_expected = CNT_W'(1);
                    n_partial  = CP_W'(b[4:0]);
                end
                LEAD_THREE: begin
                    n_expected = CNT_W'(2);
                    n_partial  = CP_W'(b[3:0]);
                end
                LEAD_FOUR: begin
                    n_expected = CNT_W'(3);
                    n_partial  = CP_W'(b[2:0]);
                end
                default: begin
                    o_result.valid = 1'b1;
                    n_discard      = !eot;
                end
            endcase
            // string ends on a lead word
            if (eot && n_expected != '0) begin
                o_result.valid = 1'b1;
                n_expected     = '0;
                n_partial      = '0;
            end
        end
        if (!i_word.valid) begin
            o_result.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= '0;
            r_partial  <= '0;
            r_discard  <= 1'b0;
        end else if (i_advance) begin
            r_expected <= n_expected;
            r_partial  <= n_partial;
            r_discard  <= n_discard;
        end
    end

endmodule

// ----- hdl/u8cp_out_reg.sv -----
module u8cp_out_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  u8cp_pkg::t_result           i_result,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [u8cp_pkg::CP_W-1:0]   o_code_point,
    output logic                        o_last,
    output logic                        o_free
);
    import u8cp_pkg::*;

    t_result r_res;

    assign o_free       = !r_res.valid || i_ready;
    assign o_valid      = r_res.valid;
    assign o_code_point = r_res.code_point;
    assign o_last       = r_res.final_code_point;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else if (o_free) begin
            r_res.valid <= i_advance && i_result.valid;
        end
        if (o_free) begin
            r_res.code_point       <= i_result.code_point;
            r_res.final_code_point <= i_result.final_code_point;
        end
    end

endmodule

// ----- hdl/utf8_to_code_point_decoder_core.sv -----
// UTF-8 decoder: takes one byte of a string per word and returns a 21-bit code
// point when a sequence completes, with tlast on the string's last code point.
// An invalid lead byte, or a string that ends inside a sequence, returns U+FFFD
// with tlast set; after an invalid lead the rest of the string is dropped.
// Continuation bytes are not checked, and overlong forms and surrogates pass.
// One byte is taken every clock unless the result register is held back; a result passes
// the input register, then the result register, and is set by the one decode stage between.
module utf8_to_code_point_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_axis_tlast    // final_code_point
);
    import u8cp_pkg::*;

    t_in_word        in_word;
    t_result         result;
    logic            advance;
    logic            out_free;
    logic [CP_W-1:0] code_point;

    assign advance = in_word.valid && out_free;
    assign m_axis_tdata = {{(TDATA_OUT_W-CP_W){1'b0}}, code_point};

    u8cp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_byte    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .i_advance (advance),
        .o_word    (in_word)
    );

    u8cp_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_word    (in_word),
        .i_advance (advance),
        .o_result  (result)
    );

    u8cp_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_result     (result),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_code_point (code_point),
        .o_last       (m_axis_tlast),
        .o_free       (out_free)
    );

endmodule

// ----- hdl/u8cp_checker.sv -----
module u8cp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

    // input side only stalls while a result is held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // fill bits above the code point stay zero
    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:21] == 3'b000))
        else $error("nonzero fill bits in result word");

    // a held result word does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result word changed");

endmodule

bind utf8_to_code_point_decoder_core u8cp_checker u_u8cp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- sim/testbench.sv -----
module testbench;

    import u8cp_pkg::*;

    localparam int unsigned RANDOM_BYTES = 1625;

    typedef enum {
        ROW_PREDICT,
        ROW_GIVEN,
        ROW_QUIET
    } t_row_mode;

    typedef struct {
        logic [7:0]      text_byte;
        logic            end_of_text;
        t_row_mode       mode;
        logic [CP_W-1:0] cp;
        logic            fin;
    } t_text_row;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            fin;
    } t_code_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    t_code_point expected_cps [$];
    t_text_row   text_q [$];
    t_text_row   cur_row;
    int unsigned sent_bytes = 0;
    int unsigned mismatch_count = 0;

    // decoder state mirror
    logic [1:0]      owed_bytes = 2'd0;
    logic [CP_W-1:0] partial_cp = '0;
    bit              dropping = 1'b0;

    t_text_row directed_rows [0:23] = '{
        '{8'h00, 1'b0, ROW_GIVEN,   21'h000000,     1'b0},
        '{8'h7F, 1'b1, ROW_GIVEN,   21'h00007F,     1'b1},
        '{8'hC2, 1'b0, ROW_QUIET,   21'h0,          1'b0},
        '{8'hA9, 1'b1, ROW_PREDICT, 21'h0,          1'b0},
        '{8'hE2, 1'b0, ROW_QUIET,   21'h0,          1'b0},
        '{8'h82, 1'b0, ROW_QUIET,   21'h0,          1'b0},
        '{8'hAC, 1'b0, ROW_PREDICT, 21'h0,          1'b0},
        '{8'hF7, 1'b0, ROW_QUIET,   21'h0,          1'b0},
        '{8'hBF, 1'b0, ROW_QUIET,   21'h0,          1'b0},
        '{8'hBF, 1'b0, ROW_QUIET,   21'h0,          1'b0},
        '{8'hBF, 1'b1, ROW_GIVEN,   21'h1FFFFF,     1'b1},
        '{8'hF0, 1'b0, ROW_QUIET,   21'h0,          1'b0},
        '{8'h9F, 1'b0, ROW_QUIET,   21'h0,          1'b0},
        '{8'h98, 1'b0, ROW_QUIET,   21'h0,          1'b0},
        '{8'h80, 1'b0, ROW_PREDICT, 21'h0,          1'b0},
        // invalid lead, rest of string dropped
        '{8'h80, 1'b0, ROW_GIVEN,   REPLACEMENT_CP, 1'b1},
        '{8'h41, 1'b0, ROW_QUIET,   21'h0,          1'b0},
        '{8'hFF, 1'b1, ROW_QUIET,   21'h0,          1'b0},
        '{8'hF8, 1'b1, ROW_GIVEN,   REPLACEMENT_CP, 1'b1},
        // string ends on a lead, then inside a sequence
        '{8'hE0, 1'b1, ROW_GIVEN,   REPLACEMENT_CP, 1'b1},
        '{8'hF0, 1'b0, ROW_QUIET,   21'h0,          1'b0},
        '{8'h90, 1'b1, ROW_GIVEN,   REPLACEMENT_CP, 1'b1},
        // continuation bytes are not checked
        '{8'hDF, 1'b0, ROW_QUIET,   21'h0,          1'b0},
        '{8'h00, 1'b1, ROW_PREDICT, 21'h0,          1'b0}
    };

    utf8_to_code_point_decoder_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void decode_byte(input logic [7:0] b, input logic eot,
                                        output bit produced, output t_code_point res);
        t_lead_kind kind;
        produced = 1'b0;
        res = '0;
        if (dropping) begin
            if (eot) dropping = 1'b0;
            return;
        end
        if (owed_bytes != 2'd0) begin
            partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
            owed_bytes = owed_bytes - 2'd1;
            if (owed_bytes == 2'd0) begin
                produced = 1'b1;
                res = '{partial_cp, eot};
                partial_cp = '0;
            end else if (eot) begin
                produced = 1'b1;
                res = '{REPLACEMENT_CP, 1'b1};
                partial_cp = '0;
                owed_bytes = 2'd0;
            end
            return;
        end
        casez (b)
            8'b0???????: kind = LEAD_ASCII;
            8'b110?????: kind = LEAD_TWO;
            8'b1110????: kind = LEAD_THREE;
            8'b11110???: kind = LEAD_FOUR;
            default:     kind = LEAD_INVALID;
        endcase
        case (kind)
            LEAD_ASCII: begin
                produced = 1'b1;
                res = '{{13'd0, b}, eot};
                return;
            end
            LEAD_TWO: begin
                owed_bytes = 2'd1;
                partial_cp = {16'd0, b[4:0]};
            end
            LEAD_THREE: begin
                owed_bytes = 2'd2;
                partial_cp = {17'd0, b[3:0]};
            end
            LEAD_FOUR: begin
                owed_bytes = 2'd3;
                partial_cp = {18'd0, b[2:0]};
            end
            default: begin
                dropping = !eot;
                produced = 1'b1;
                res = '{REPLACEMENT_CP, 1'b1};
                return;
            end
        endcase
        if (eot) begin
            owed_bytes = 2'd0;
            partial_cp = '0;
            produced = 1'b1;
            res = '{REPLACEMENT_CP, 1'b1};
        end
    endfunction

    function automatic void queue_expected(input t_code_point cp);
        expected_cps = {expected_cps, cp};
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100) $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic take_byte(input t_text_row row);
        bit          produced;
        t_code_point res;
        sent_bytes++;
        decode_byte(row.text_byte, row.end_of_text, produced, res);
        case (row.mode)
            ROW_GIVEN: queue_expected('{row.cp, row.fin});
            ROW_QUIET: ;
            default:   if (produced) queue_expected(res);
        endcase
    endtask

    task automatic check_code_point(input logic [23:0] data, input logic last);
        t_code_point want;
        if (expected_cps.size() == 0) begin
            report_mismatch($sformatf("unexpected code point %h", data[CP_W-1:0]));
            return;
        end
        want = expected_cps.pop_front();
        if (data[CP_W-1:0] !== want.cp)
            report_mismatch($sformatf("code point %h, want %h", data[CP_W-1:0], want.cp));
        if (last !== want.fin)
            report_mismatch($sformatf("final flag %b, want %b on %h", last, want.fin,
                                      want.cp));
        if (data[23:CP_W] !== '0)
            report_mismatch($sformatf("padding bits %b not zero", data[23:CP_W]));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) take_byte(cur_row);
            if (m_axis_tvalid && m_axis_tready) check_code_point(m_axis_tdata, m_axis_tlast);
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_text_row make_row(input logic [7:0] b);
        t_text_row row;
        row = '{b, 1'b0, ROW_PREDICT, '0, 1'b0};
        return row;
    endfunction

    task automatic build_string();
        int unsigned style;
        int unsigned chars;
        int unsigned nbytes;
        logic [7:0]  lead;
        logic [7:0]  bad;
        style = $urandom_range(0, 99);
        chars = $urandom_range(1, 6);
        text_q.delete();
        if (style < 8) begin
            // noise
            repeat (chars * 2) text_q = {text_q, make_row(8'($urandom_range(0, 255)))};
        end else begin
            repeat (chars) begin
                nbytes = $urandom_range(1, 4);
                case (nbytes)
                    1:       lead = 8'($urandom_range(8'h00, 8'h7F));
                    2:       lead = 8'($urandom_range(8'hC0, 8'hDF));
                    3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
                    default: lead = 8'($urandom_range(8'hF0, 8'hF7));
                endcase
                text_q = {text_q, make_row(lead)};
                repeat (nbytes - 1) begin
                    if ($urandom_range(0, 15) == 0)
                        text_q = {text_q, make_row(8'($urandom_range(0, 255)))};
                    else
                        text_q = {text_q, make_row(8'($urandom_range(8'h80, 8'hBF)))};
                end
            end
            if (style < 16) begin
                // truncated tail
                repeat ($urandom_range(1, 2))
                    if (text_q.size() > 1) void'(text_q.pop_back());
            end else if (style < 24) begin
                bad = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                           : 8'($urandom_range(8'hF8, 8'hFF));
                text_q.insert($urandom_range(0, text_q.size()), make_row(bad));
            end
        end
        text_q[text_q.size()-1].end_of_text = 1'b1;
    endtask

    task automatic send_byte(input t_text_row row, input int unsigned gap);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row.text_byte;
        s_axis_tlast  <= row.end_of_text;
        cur_row       <= row;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_cps.size() != 0) @(posedge i_clk);
    endtask

    // result side back-pressure
    initial begin
        int unsigned stall;
        bit          calm;
        stall = 0;
        calm  = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 299) == 0) calm = !calm;
            if (stall == 0 && !calm && $urandom_range(0, 7) == 0)
                stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                    : $urandom_range(8, 30);
            m_axis_tready <= (stall == 0);
            if (stall != 0) stall--;
        end
    end

    initial begin
        int unsigned start_count;
        bit          paused;
        bit          no_gaps;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) send_byte(directed_rows[i], pick_gap());
        drain_results();

        start_count = sent_bytes;
        paused = 1'b0;
        while (sent_bytes - start_count < RANDOM_BYTES) begin
            build_string();
            no_gaps = ($urandom_range(0, 4) == 0);
            foreach (text_q[i]) send_byte(text_q[i], no_gaps ? 0 : pick_gap());
            if (!paused && sent_bytes - start_count > RANDOM_BYTES / 2) begin
                paused = 1'b1;
                drain_results();
            end
        end
        drain_results();
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
